/* rtl/vector_position_integrator_unit_assert.svh */
// Assertion macros for the vector position integrator
`ifndef VECTOR_POSITION_INTEGRATOR_UNIT_ASSERT_SVH
`define VECTOR_POSITION_INTEGRATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define VPI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VPI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/vpi_pkg.sv */
// Shared types, constants and codes of the vector position integrator
package vpi_pkg;

  localparam int FracBits = 4;
  localparam int CoordW   = 32;
  localparam int CfgW     = 12;
  localparam int CfgIdxW  = 2;
  localparam int NumAxes  = 3;

  // cfg register indexes
  localparam logic [CfgIdxW-1:0] CfgDirX  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDirY  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDirZ  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpeed = 2'd3;

  // set position saturation
  localparam logic [CoordW-1:0] PosLimit = {CoordW{1'b1}} >> FracBits;
  localparam logic [CoordW-1:0] PosSat   = {CoordW{1'b1}} << FracBits;

  typedef enum logic [1:0] {
    OpTick      = 2'd0,
    OpSetPos    = 2'd1,
    OpTranslate = 2'd2,
    OpHold      = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic signed [31:0] z_value;
    logic               has_parent;
    logic signed [31:0] parent_x;
    logic signed [31:0] parent_y;
    logic signed [31:0] parent_z;
  } vpi_req_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } vpi_rsp_t;

  // classified request held in the front queue
  typedef struct packed {
    op_e                             op;
    logic [NumAxes-1:0][CoordW-1:0]  arg;
  } vpi_cmd_t;

  // cached increments as seen by the back end
  typedef struct packed {
    logic                            valid;
    logic [NumAxes-1:0][CoordW-1:0]  inc;
  } vpi_incr_t;

endpackage

/* rtl/vpi_front.sv */
// Front end: accepts requests, pre-computes operands, queues them
module vpi_front import vpi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  vpi_req_t in_req_i,
  output logic     cmd_valid_o,
  input  logic     cmd_ready_i,
  output vpi_cmd_t cmd_o
);

  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  vpi_cmd_t                       mem_q [QDepth];
  logic [QPtrW-1:0]               wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0]               cnt_q, cnt_d;
  logic                           push, pop;
  vpi_cmd_t                       cmd_new;
  logic [NumAxes-1:0][CoordW-1:0] val, par;

  assign val[0] = in_req_i.x_value;
  assign val[1] = in_req_i.y_value;
  assign val[2] = in_req_i.z_value;
  assign par[0] = in_req_i.parent_x;
  assign par[1] = in_req_i.parent_y;
  assign par[2] = in_req_i.parent_z;

  always_comb begin
    cmd_new.op = op_e'(in_req_i.operation);
    for (int i = 0; i < NumAxes; i++) begin
      unique case (cmd_new.op)
        OpSetPos: begin
          cmd_new.arg[i] = (val[i] > PosLimit) ? PosSat : (val[i] << FracBits);
        end
        OpTranslate: begin
          cmd_new.arg[i] = val[i] + (in_req_i.has_parent ? par[i] : '0);
        end
        OpTick, OpHold: begin
          cmd_new.arg[i] = val[i];
        end
      endcase
    end
  end

  assign in_ready_o  = (cnt_q != QCntW'(QDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == QPtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == QPtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cmd_new;
    end
  end

endmodule

/* rtl/vpi_incr.sv */
// Config registers and sequential per-axis increment engine
module vpi_incr import vpi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               start_i,
  output vpi_incr_t          incr_o
);

  localparam int MagW   = CfgW;                       // |-2048| fits unsigned
  localparam int ProdW  = 2 * MagW;                   // |d|*|s|
  localparam int Len2W  = 2 * MagW + 2;               // sum of three squares
  localparam int DivW   = 2 * ProdW + 2 * FracBits;   // (|d|*|s| << frac)^2
  localparam int SqW    = 2 * (MagW + FracBits);      // quotient bound
  localparam int RootW  = SqW / 2;
  localparam int CntW   = $clog2(DivW);
  localparam int AxisW  = $clog2(NumAxes);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StLen    = 3'd1;
  localparam logic [2:0] StProd   = 3'd2;
  localparam logic [2:0] StSqr    = 3'd3;
  localparam logic [2:0] StDiv    = 3'd4;
  localparam logic [2:0] StRootLd = 3'd5;
  localparam logic [2:0] StRoot   = 3'd6;

  localparam logic [AxisW-1:0] LastAxis = AxisW'(NumAxes - 1);

  logic [2:0]                     state_q, state_d;
  logic                           valid_q, valid_d;
  logic [NumAxes-1:0][CoordW-1:0] inc_q, inc_d;
  logic [NumAxes-1:0][CfgW-1:0]   dir_q, dir_d;
  logic [CfgW-1:0]                speed_q, speed_d;
  logic [AxisW-1:0]               axis_q, axis_d;
  logic [Len2W-1:0]               len2_q, len2_d;
  logic [ProdW-1:0]               mag_q, mag_d;
  logic                           neg_q, neg_d, zero_q, zero_d;
  logic [DivW-1:0]                div_q, div_d;
  logic [Len2W-1:0]               rem_q, rem_d;
  logic [CntW-1:0]                cnt_q, cnt_d;
  logic [SqW-1:0]                 sqv_q, sqv_d, root_q, root_d, bit_q, bit_d;

  logic [CfgW-1:0]    dir_sel;
  logic [MagW-1:0]    dmag, smag;
  logic [ProdW-1:0]   mul_a, mul_b;
  logic [2*ProdW-1:0] mul;
  logic [Len2W:0]     rem_sh, rem_sub;
  logic               div_ge;
  logic [SqW:0]       rt_sum;
  logic               rt_ge;
  logic [SqW-1:0]     root_nx;
  logic [CoordW-1:0]  root_ext;
  logic               next_axis;

  assign dir_sel = dir_q[axis_q];
  assign dmag    = dir_sel[CfgW-1] ? MagW'(-dir_sel) : dir_sel;
  assign smag    = speed_q[CfgW-1] ? MagW'(-speed_q) : speed_q;

  // one shared multiplier, result registered by every consumer
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      StLen: begin
        mul_a = ProdW'(dmag);
        mul_b = ProdW'(dmag);
      end
      StProd: begin
        mul_a = ProdW'(dmag);
        mul_b = ProdW'(smag);
      end
      StSqr: begin
        mul_a = mag_q;
        mul_b = mag_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul = mul_a * mul_b;

  // restoring divide, one quotient bit per cycle
  assign rem_sh  = {rem_q, div_q[DivW-1]};
  assign div_ge  = (rem_sh >= {1'b0, len2_q});
  assign rem_sub = rem_sh - {1'b0, len2_q};

  // digit-by-digit square root, one result bit per cycle
  assign rt_sum   = {1'b0, root_q} + {1'b0, bit_q};
  assign rt_ge    = ({1'b0, sqv_q} >= rt_sum);
  assign root_nx  = rt_ge ? ((root_q >> 1) + bit_q) : (root_q >> 1);
  assign root_ext = CoordW'(root_nx[RootW-1:0]);

  always_comb begin
    state_d   = state_q;
    valid_d   = valid_q;
    inc_d     = inc_q;
    dir_d     = dir_q;
    speed_d   = speed_q;
    axis_d    = axis_q;
    len2_d    = len2_q;
    mag_d     = mag_q;
    neg_d     = neg_q;
    zero_d    = zero_q;
    div_d     = div_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    sqv_d     = sqv_q;
    root_d    = root_q;
    bit_d     = bit_q;
    next_axis = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (start_i && !valid_q) begin
          axis_d  = '0;
          len2_d  = '0;
          state_d = StLen;
        end
      end
      StLen: begin
        len2_d = len2_q + Len2W'(mul[2*MagW-1:0]);
        if (axis_q == LastAxis) begin
          axis_d  = '0;
          state_d = StProd;
        end else begin
          axis_d = axis_q + 1'b1;
        end
      end
      StProd: begin
        mag_d   = mul[ProdW-1:0];
        neg_d   = dir_sel[CfgW-1] ^ speed_q[CfgW-1];
        zero_d  = (len2_q == '0) || (dir_sel == '0) || (speed_q == '0);
        state_d = StSqr;
      end
      StSqr: begin
        if (zero_q) begin
          inc_d[axis_q] = '0;
          next_axis     = 1'b1;
        end else begin
          div_d   = {mul, {(2*FracBits){1'b0}}};
          rem_d   = '0;
          cnt_d   = '0;
          state_d = StDiv;
        end
      end
      StDiv: begin
        rem_d = div_ge ? rem_sub[Len2W-1:0] : rem_sh[Len2W-1:0];
        div_d = {div_q[DivW-2:0], div_ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivW - 1)) begin
          state_d = StRootLd;
        end
      end
      StRootLd: begin
        sqv_d   = div_q[SqW-1:0];
        root_d  = '0;
        bit_d   = SqW'(1) << (SqW - 2);
        cnt_d   = '0;
        state_d = StRoot;
      end
      StRoot: begin
        if (rt_ge) begin
          sqv_d = sqv_q - rt_sum[SqW-1:0];
        end
        root_d = root_nx;
        bit_d  = bit_q >> 2;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CntW'(RootW - 1)) begin
          inc_d[axis_q] = neg_q ? ('0 - root_ext) : root_ext;
          next_axis     = 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (next_axis) begin
      if (axis_q == LastAxis) begin
        axis_d  = '0;
        valid_d = 1'b1;
        state_d = StIdle;
      end else begin
        axis_d  = axis_q + 1'b1;
        state_d = StProd;
      end
    end

    // a config write always drops the cache
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDirX:  dir_d[0] = cfg_data_i;
        CfgDirY:  dir_d[1] = cfg_data_i;
        CfgDirZ:  dir_d[2] = cfg_data_i;
        CfgSpeed: speed_d  = cfg_data_i;
      endcase
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= 1'b0;
      inc_q   <= '0;
      dir_q   <= '0;
      speed_q <= '0;
      axis_q  <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      inc_q   <= inc_d;
      dir_q   <= dir_d;
      speed_q <= speed_d;
      axis_q  <= axis_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len2_q <= len2_d;
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
    div_q  <= div_d;
    rem_q  <= rem_d;
    cnt_q  <= cnt_d;
    sqv_q  <= sqv_d;
    root_q <= root_d;
    bit_q  <= bit_d;
  end

  assign incr_o.valid = valid_q;
  assign incr_o.inc   = inc_q;

endmodule

/* rtl/vpi_back.sv */
// Back end: position state, request execution and output register
module vpi_back import vpi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_ready_o,
  input  vpi_cmd_t  cmd_i,
  input  vpi_incr_t incr_i,
  output logic      start_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output vpi_rsp_t  out_rsp_o
);

  logic [NumAxes-1:0][CoordW-1:0] pos_q, pos_d, res;
  logic                           out_valid_q, out_valid_d;
  vpi_rsp_t                       out_q, out_d;
  logic                           slot_free, is_tick, fire;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign is_tick     = (cmd_i.op == OpTick);
  // a tick waits here until the increments are cached
  assign cmd_ready_o = slot_free && (!is_tick || incr_i.valid);
  assign start_o     = cmd_valid_i && is_tick && !incr_i.valid;
  assign fire        = cmd_valid_i && cmd_ready_o;

  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      unique case (cmd_i.op)
        OpTick:      res[i] = pos_q[i] + incr_i.inc[i];
        OpSetPos:    res[i] = cmd_i.arg[i];
        OpTranslate: res[i] = cmd_i.arg[i] + pos_q[i];
        OpHold:      res[i] = pos_q[i];
      endcase
    end
  end

  always_comb begin
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (fire) begin
      out_valid_d = 1'b1;
      out_d.out_x = res[0];
      out_d.out_y = res[1];
      out_d.out_z = res[2];
      if (cmd_i.op == OpTick || cmd_i.op == OpSetPos) begin
        pos_d = res;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

/* rtl/vector_position_integrator_unit.sv */
// Usage: 3D mover with 28.4 fixed-point position, direction and speed in config.
// Requests (tick, set position, translate point, hold) come in as a vpi_req_t
// on in_valid_i/in_ready_o; each gives one vpi_rsp_t on out_valid_o/out_ready_i.
// Config is written on cfg_we_i/cfg_idx_i/cfg_data_i (0..2 direction, 3 speed)
// while no request is in flight; any write drops the cached increments.
// A request passes the queue and the output register; one request per cycle
// sustained while results are taken and no tick waits for increments.
// The first tick after a config write first runs the increment engine: one
// shared 24x24 multiplier, a 56-step restoring divider and a 16-step square
// root per axis; divider and root are skipped on an axis with zero direction
// or speed. Later ticks reuse the cached increments; other requests do not wait.
// A two-entry request queue sits between front and back, so input keeps
// flowing for two requests while the receiver stalls; the result register
// holds its value until taken, and the back end stops behind it.
// Reset clears position, increments, config and the queue; the cache starts
// invalid, so the first tick computes increments (zero after reset).
module vector_position_integrator_unit import vpi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vpi_req_t           in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output vpi_rsp_t           out_rsp_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  logic      cmd_valid, cmd_ready, incr_start;
  vpi_cmd_t  cmd;
  vpi_incr_t incr;

  vpi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  vpi_incr u_incr (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .start_i    (incr_start),
    .incr_o     (incr)
  );

  vpi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .incr_i      (incr),
    .start_o     (incr_start),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

`include "vector_position_integrator_unit_assert.svh"

  `VPI_ASSERT_NOW(a_tick_uses_cache, cmd_valid && cmd_ready && cmd.op == OpTick, incr.valid, "tick executed with stale increments")
  `VPI_ASSERT_NEXT(a_cfg_drops_cache, cfg_we_i, !incr.valid, "config write left increments valid")
  `VPI_ASSERT_NEXT(a_push_queued, in_valid_i && in_ready_o, cmd_valid, "accepted request missing from queue")

endmodule

/* dv/vector_position_integrator_unit_tb.sv */
// Self-checking testbench for the vector position integrator unit
`timescale 1ns / 1ps

module vector_position_integrator_unit_tb;
  import vpi_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int TailCycles = 20;
  localparam int NumRows    = 25;
  localparam int NumPhases  = 12;
  localparam int PhaseItems = 73;

  typedef enum logic [1:0] {
    RowReq,  // request, result from the predictor
    RowLit,  // request, result given in the row
    RowCfg   // register write: a/b/c = direction, pa = speed
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    op_e         op;
    logic [31:0] a, b, c;
    logic        hp;
    logic [31:0] pa, pb, pc;
    logic [31:0] ea, eb, ec;
  } row_t;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_ready_o;
  vpi_req_t        in_req_i    = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  vpi_rsp_t        out_rsp_o;
  logic            cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CfgDirX;
  logic [CfgW-1:0] cfg_data_i  = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int cycle_count    = 0;

  // mover state mirrored by the testbench
  logic signed [11:0] heading_q [3] = '{12'sd0, 12'sd0, 12'sd0};
  logic signed [11:0] speed_q       = 12'sd0;
  logic [31:0]        pos_q  [3]    = '{32'd0, 32'd0, 32'd0};
  logic [31:0]        step_q [3]    = '{32'd0, 32'd0, 32'd0};
  bit                 steps_fresh   = 1'b0;

  vpi_rsp_t coords_due [$];

  row_t script [NumRows] = '{
    '{RowLit, OpTick, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0, 32'h0,
      32'h0, 32'h0, 32'h0},
    '{RowLit, OpHold, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1,
      32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 32'h0, 32'h0},
    '{RowLit, OpSetPos, 32'hFFFFFFFF, 32'h10000000, 32'h0FFFFFFF, 1'b0,
      32'h0, 32'h0, 32'h0, 32'hFFFFFFF0, 32'hFFFFFFF0, 32'hFFFFFFF0},
    '{RowLit, OpTick, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0, 32'h0,
      32'hFFFFFFF0, 32'hFFFFFFF0, 32'hFFFFFFF0},
    // parent fields set but not selected
    '{RowLit, OpTranslate, 32'h10, 32'h20, 32'h7FFFFFFF, 1'b0,
      32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 32'h10, 32'h7FFFFFEF},
    '{RowLit, OpTranslate, 32'h0, 32'h80000000, 32'h1, 1'b1,
      32'h10, 32'h80000000, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFF0, 32'hFFFFFFF0},
    '{RowLit, OpSetPos, 32'h1, 32'h0FFFFFFE, 32'h80000000, 1'b0,
      32'h0, 32'h0, 32'h0, 32'h10, 32'hFFFFFFE0, 32'hFFFFFFF0},
    '{RowLit, OpHold, 32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 1'b1,
      32'h1, 32'h2, 32'h3, 32'h10, 32'hFFFFFFE0, 32'hFFFFFFF0},
    // unit x axis, most negative speed: step is exactly -2048.0
    '{RowCfg, OpHold, 32'h1, 32'h0, 32'h0, 1'b0, 32'h800, 32'h0, 32'h0,
      32'h0, 32'h0, 32'h0},
    '{RowLit, OpTick, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0, 32'h0,
      32'hFFFF8010, 32'hFFFFFFE0, 32'hFFFFFFF0},
    '{RowLit, OpTick, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0, 32'h0,
      32'hFFFF0010, 32'hFFFFFFE0, 32'hFFFFFFF0},
    '{RowCfg, OpHold, 32'h800, 32'h7FF, 32'h0, 1'b0, 32'h7FF, 32'h0, 32'h0,
      32'h0, 32'h0, 32'h0},
    '{RowReq, OpTick, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0, 32'h0,
      32'h0, 32'h0, 32'h0},
    '{RowReq, OpTick, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1,
      32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 32'h0, 32'h0},
    '{RowReq, OpTranslate, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 1'b1,
      32'h7FFFFFFF, 32'h80000000, 32'h1, 32'h0, 32'h0, 32'h0},
    // zero direction with full speed
    '{RowCfg, OpHold, 32'h0, 32'h0, 32'h0, 1'b0, 32'h7FF, 32'h0, 32'h0,
      32'h0, 32'h0, 32'h0},
    '{RowReq, OpTick, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0, 32'h0,
      32'h0, 32'h0, 32'h0},
    // zero speed
    '{RowCfg, OpHold, 32'h7FF, 32'h7FF, 32'h7FF, 1'b0, 32'h0, 32'h0, 32'h0,
      32'h0, 32'h0, 32'h0},
    '{RowReq, OpTick, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0, 32'h0,
      32'h0, 32'h0, 32'h0},
    '{RowCfg, OpHold, 32'h801, 32'h800, 32'hFFF, 1'b0, 32'hFFF, 32'h0, 32'h0,
      32'h0, 32'h0, 32'h0},
    '{RowReq, OpTick, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0, 32'h0,
      32'h0, 32'h0, 32'h0},
    '{RowReq, OpTick, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0, 32'h0,
      32'h0, 32'h0, 32'h0},
    '{RowLit, OpSetPos, 32'h0FFFFFFF, 32'h10000000, 32'h0, 1'b0,
      32'h0, 32'h0, 32'h0, 32'hFFFFFFF0, 32'hFFFFFFF0, 32'h0},
    '{RowReq, OpTick, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0, 32'h0,
      32'h0, 32'h0, 32'h0},
    '{RowReq, OpTranslate, 32'h55555555, 32'hAAAAAAAA, 32'h0, 1'b1,
      32'hAAAAAAAA, 32'h55555555, 32'h80000000, 32'h0, 32'h0, 32'h0}
  };

  logic [11:0] corner_cfg [4][4] = '{
    '{12'h800, 12'h800, 12'h800, 12'h800},
    '{12'h7FF, 12'h7FF, 12'h7FF, 12'h7FF},
    '{12'h000, 12'h000, 12'h000, 12'h800},
    '{12'h001, 12'h000, 12'h000, 12'h001}
  };

  vector_position_integrator_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // floor(sqrt(v)), built bit by bit from the top
  function automatic logic [31:0] int_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= v) root = trial;
    end
    return root[31:0];
  endfunction

  // per-tick step = trunc(2^FracBits * d * speed / |d|), done in integers
  function automatic void derive_steps();
    longint      d [3];
    longint      len2;
    longint      p;
    logic [63:0] mag;
    logic [31:0] root;
    for (int k = 0; k < 3; k++) d[k] = longint'(heading_q[k]);
    len2 = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
    for (int k = 0; k < 3; k++) begin
      p = d[k] * longint'(speed_q);
      if (len2 == 0 || p == 0) begin
        step_q[k] = '0;
      end else begin
        mag  = (p < 0) ? 64'(-p) : 64'(p);
        mag  = mag << FracBits;
        root = int_sqrt((mag * mag) / 64'(len2));
        step_q[k] = (p < 0) ? 32'd0 - root : root;
      end
    end
    steps_fresh = 1'b1;
  endfunction

  function automatic vpi_rsp_t mover_step(input vpi_req_t r);
    logic [31:0] arg [3];
    logic [31:0] par [3];
    logic [31:0] res [3];
    vpi_rsp_t    rsp;
    arg = '{r.x_value, r.y_value, r.z_value};
    par = '{r.parent_x, r.parent_y, r.parent_z};
    res = pos_q;
    case (op_e'(r.operation))
      OpTick: begin
        if (!steps_fresh) derive_steps();
        for (int k = 0; k < 3; k++) begin
          pos_q[k] = pos_q[k] + step_q[k];
          res[k]   = pos_q[k];
        end
      end
      OpSetPos: begin
        for (int k = 0; k < 3; k++) begin
          pos_q[k] = (arg[k] > PosLimit) ? PosSat : arg[k] << FracBits;
          res[k]   = pos_q[k];
        end
      end
      OpTranslate: begin
        for (int k = 0; k < 3; k++)
          res[k] = arg[k] + pos_q[k] + (r.has_parent ? par[k] : 32'd0);
      end
      default: ;
    endcase
    rsp.out_x = res[0];
    rsp.out_y = res[1];
    rsp.out_z = res[2];
    return rsp;
  endfunction

  function automatic void check_axis(input string axis, input logic [31:0] want,
                                     input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: out_%s mismatch, expected %h, got %h", $time, axis, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : rsp_monitor
    vpi_rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (coords_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, out_rsp_o);
        mismatches++;
      end else begin
        want = coords_due.pop_front();
        check_axis("x", want.out_x, out_rsp_o.out_x);
        check_axis("y", want.out_y, out_rsp_o.out_y);
        check_axis("z", want.out_z, out_rsp_o.out_z);
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // call at a rising edge; returns at the edge where the request was taken
  task automatic push_req(input vpi_req_t req, input bit fixed,
                          input vpi_rsp_t fixed_rsp);
    int       gap;
    vpi_rsp_t got;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    got = mover_step(req);
    coords_due.push_back(fixed ? fixed_rsp : got);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (coords_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [11:0] dx, input logic [11:0] dy,
                              input logic [11:0] dz, input logic [11:0] sp);
    logic [CfgIdxW-1:0] idx [4];
    logic [11:0]        val [4];
    idx = '{CfgDirX, CfgDirY, CfgDirZ, CfgSpeed};
    val = '{dx, dy, dz, sp};
    for (int k = 0; k < 4; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[k];
      cfg_data_i <= val[k];
      case (idx[k])
        CfgDirX:  heading_q[0] = val[k];
        CfgDirY:  heading_q[1] = val[k];
        CfgDirZ:  heading_q[2] = val[k];
        CfgSpeed: speed_q      = val[k];
        default: ;
      endcase
      steps_fresh = 1'b0;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [11:0] random_cfg_val();
    case ($urandom_range(7))
      0:       return 12'h000;
      1:       return 12'h800;
      2:       return 12'h7FF;
      default: return 12'($urandom_range(4095));
    endcase
  endfunction

  // set position argument: full range, the saturation edge, or in range
  function automatic logic [31:0] random_pos_arg();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return PosLimit + 32'($urandom_range(1));
      default: return $urandom_range(PosLimit);
    endcase
  endfunction

  function automatic vpi_req_t random_req();
    vpi_req_t r;
    int       pick;
    r.x_value    = $urandom;
    r.y_value    = $urandom;
    r.z_value    = $urandom;
    r.has_parent = 1'($urandom_range(1));
    r.parent_x   = $urandom;
    r.parent_y   = $urandom;
    r.parent_z   = $urandom;
    pick = $urandom_range(99);
    if (pick < 40) begin
      r.operation = OpTick;
    end else if (pick < 60) begin
      r.operation = OpSetPos;
      r.x_value   = random_pos_arg();
      r.y_value   = random_pos_arg();
      r.z_value   = random_pos_arg();
    end else if (pick < 95) begin
      r.operation = OpTranslate;
    end else begin
      r.operation = OpHold;
    end
    return r;
  endfunction

  initial begin : stimulus
    row_t     row;
    vpi_req_t req;
    vpi_rsp_t lit;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      row = script[i];
      if (row.kind == RowCfg) begin
        drain_results();
        program_regs(row.a[11:0], row.b[11:0], row.c[11:0], row.pa[11:0]);
      end else begin
        req.operation  = row.op;
        req.x_value    = row.a;
        req.y_value    = row.b;
        req.z_value    = row.c;
        req.has_parent = row.hp;
        req.parent_x   = row.pa;
        req.parent_y   = row.pb;
        req.parent_z   = row.pc;
        lit.out_x      = row.ea;
        lit.out_y      = row.eb;
        lit.out_z      = row.ec;
        push_req(req, row.kind == RowLit, lit);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain_results();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      if (ph < 4)
        program_regs(corner_cfg[ph][0], corner_cfg[ph][1], corner_cfg[ph][2],
                     corner_cfg[ph][3]);
      else
        program_regs(random_cfg_val(), random_cfg_val(), random_cfg_val(),
                     random_cfg_val());
      for (int n = 0; n < PhaseItems; n++) begin
        // now and then let the pipe run dry mid-phase
        if ($urandom_range(63) == 0) drain_results();
        push_req(random_req(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
